// ===== rtl/interpolating_table_lookup_unit_assert.svh =====
// Assertion macros for the table lookup RTL.
// Included by modules that carry concurrent checks; needs signals clock and reset in scope.
`ifndef INTERPOLATING_TABLE_LOOKUP_UNIT_ASSERT_SVH
`define INTERPOLATING_TABLE_LOOKUP_UNIT_ASSERT_SVH

// condition must hold on every edge out of reset
`define ITLU_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define ITLU_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ITLU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/itlu_pkg.sv =====
// Shared types and constants of the interpolating table lookup unit.
// No dependencies; imported by the top level, itlu_scale and itlu_blend.
package itlu_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 256;
   localparam int DEFAULT_FRAC_BITS   = 16;
   localparam int DATA_W              = 32;
   localparam int SLOT_W              = 8;
   localparam int LENGTH_W            = 9;
   localparam int CSR_ADDR_W          = 4;
   localparam int CSR_DATA_W          = 32;

   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_ENTRY,
      KIND_SCALED,
      KIND_BLEND
   } kind_type;

   typedef enum logic [1:0] {
      REG_CLAMP_MODE   = 2'd0,
      REG_SNAP_MODE    = 2'd1,
      REG_TABLE_LENGTH = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } stage_ctrl_type;

endpackage

// ===== rtl/interpolating_table_lookup_unit.sv =====
// Interpolating table lookup unit: takes one word per cycle on the req channel while
// rsp_ready holds, either a table entry write or a lookup. Each lookup gives one rsp word,
// passing the input register at acceptance, then scale multiply, table read, interpolation
// multiply, sum and result register; a write gives none and updates the table from stage 2,
// ahead of any later lookup. The sustained rate is one word per cycle while rsp_ready holds,
// set by the single write and dual read port of the table RAM. Table entries hold no defined
// value until written and are not cleared at reset; the APB registers clamp_mode, snap_mode
// and table_length lie at 0x0, 0x4 and 0x8.
// Depends on itlu_pkg, itlu_ram, itlu_scale and itlu_blend.
module interpolating_table_lookup_unit #(
   parameter int TABLE_DEPTH = itlu_pkg::DEFAULT_TABLE_DEPTH,
   parameter int FRAC_BITS   = itlu_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [itlu_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [itlu_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [itlu_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic [itlu_pkg::SLOT_W-1:0]          req_entry_slot,
   input  logic signed [itlu_pkg::DATA_W-1:0]   req_entry_value,
   input  logic signed [itlu_pkg::DATA_W-1:0]   req_lookup_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [itlu_pkg::DATA_W-1:0]   rsp_result_value
);

   import itlu_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic                  clamp_mode_ff, clamp_mode_in;
   logic                  snap_mode_ff, snap_mode_in;
   logic [LENGTH_W-1:0]   table_length_ff, table_length_in;
   logic                  csr_write;
   reg_index_type         csr_index;

   logic                  ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]     ram_wr_addr, ram_rd_addr_a, ram_rd_addr_b;
   logic [DATA_W-1:0]     ram_wr_data, ram_rd_data_a, ram_rd_data_b;
   stage_ctrl_type        s3_ctrl;
   logic [FRAC_BITS-1:0]  s3_frac;
   logic                  s4_ready;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_comb begin
      clamp_mode_in   = clamp_mode_ff;
      snap_mode_in    = snap_mode_ff;
      table_length_in = table_length_ff;
      prdata          = '0;
      unique case (csr_index)
         REG_CLAMP_MODE: begin
            prdata = CSR_DATA_W'(clamp_mode_ff);
            if (csr_write) begin
               clamp_mode_in = pwdata[0];
            end
         end
         REG_SNAP_MODE: begin
            prdata = CSR_DATA_W'(snap_mode_ff);
            if (csr_write) begin
               snap_mode_in = pwdata[0];
            end
         end
         REG_TABLE_LENGTH: begin
            prdata = CSR_DATA_W'(table_length_ff);
            if (csr_write) begin
               table_length_in = pwdata[LENGTH_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_mode_ff   <= 1'b0;
         snap_mode_ff    <= 1'b0;
         table_length_ff <= '0;
      end else begin
         clamp_mode_ff   <= clamp_mode_in;
         snap_mode_ff    <= snap_mode_in;
         table_length_ff <= table_length_in;
      end
   end

   itlu_scale #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_scale (
      .clock            (clock),
      .reset            (reset),
      .clamp_mode       (clamp_mode_ff),
      .snap_mode        (snap_mode_ff),
      .table_length     (table_length_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_entry_slot   (req_entry_slot),
      .req_entry_value  (req_entry_value),
      .req_lookup_index (req_lookup_index),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr_a    (ram_rd_addr_a),
      .ram_rd_addr_b    (ram_rd_addr_b),
      .s4_ready         (s4_ready),
      .s3_ctrl          (s3_ctrl),
      .s3_frac          (s3_frac)
   );

   itlu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   itlu_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock            (clock),
      .reset            (reset),
      .s3_ctrl          (s3_ctrl),
      .s3_frac          (s3_frac),
      .entry_a          (ram_rd_data_a),
      .entry_b          (ram_rd_data_b),
      .s4_ready         (s4_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value)
   );

endmodule

// ===== rtl/itlu_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module itlu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/itlu_scale.sv =====
// Front pipeline: input word register, index clamp/wrap and scaling, table addressing.
// Depends on itlu_pkg and the assertion macro header; drives the table RAM ports.
`include "interpolating_table_lookup_unit_assert.svh"

module itlu_scale #(
   parameter int TABLE_DEPTH = 256,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 clamp_mode,
   input  logic                                 snap_mode,
   input  logic [itlu_pkg::LENGTH_W-1:0]        table_length,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic [itlu_pkg::SLOT_W-1:0]          req_entry_slot,
   input  logic signed [itlu_pkg::DATA_W-1:0]   req_entry_value,
   input  logic signed [itlu_pkg::DATA_W-1:0]   req_lookup_index,
   output logic                                 ram_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]       ram_wr_addr,
   output logic [itlu_pkg::DATA_W-1:0]          ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]       ram_rd_addr_a,
   output logic [$clog2(TABLE_DEPTH)-1:0]       ram_rd_addr_b,
   input  logic                                 s4_ready,
   output itlu_pkg::stage_ctrl_type             s3_ctrl,
   output logic [FRAC_BITS-1:0]                 s3_frac
);

   import itlu_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W  = FRAC_BITS + 1;
   localparam int SC_W   = IDX_W + LEN_W;
   localparam int WIDE_W = ((ADDR_W > SLOT_W) ? ADDR_W : SLOT_W) + 1;
   localparam int CMP_W  = ((LEN_W > LENGTH_W) ? LEN_W : LENGTH_W) + 1;
   localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(64'd1 << FRAC_BITS);

   // stage 1: accepted word
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_write_ff;
   logic [SLOT_W-1:0]        s1_slot_ff;
   logic [DATA_W-1:0]        s1_value_ff;
   logic signed [DATA_W-1:0] s1_index_ff;

   // stage 2: scaled index
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_write_ff;
   logic [SLOT_W-1:0]        s2_slot_ff;
   logic [DATA_W-1:0]        s2_value_ff;
   kind_type                 s2_kind_ff;
   logic [ADDR_W-1:0]        s2_addr_ff;
   logic [SC_W-1:0]          s2_scaled_ff;

   // stage 3: side data next to the RAM read register
   logic                     s3_valid_ff, s3_valid_in;
   kind_type                 s3_kind_ff;
   logic [FRAC_BITS-1:0]     s3_frac_ff;

   logic                     ready_1, ready_2, ready_3;
   logic [LEN_W-1:0]         len_eff, len_last;
   kind_type                 kind1, kind2;
   logic [ADDR_W-1:0]        addr1, addr2, left, right;
   logic [IDX_W-1:0]         idx_u;
   logic [LEN_W-1:0]         mult;
   logic [SC_W-1:0]          scaled1;
   logic [LEN_W-1:0]         right_inc;
   logic [WIDE_W-1:0]        slot_wide;
   logic                     slot_ok;

   assign ready_3   = !s3_valid_ff || s4_ready;
   assign ready_2   = !s2_valid_ff || ready_3;
   assign ready_1   = !s1_valid_ff || ready_2;
   assign req_ready = ready_1;

   always_comb begin
      if (CMP_W'(table_length) > CMP_W'(TABLE_DEPTH)) begin
         len_eff = LEN_W'(TABLE_DEPTH);
      end else begin
         len_eff = LEN_W'(table_length);
      end
      len_last = len_eff - LEN_W'(1);
   end

   always_comb begin
      kind1 = KIND_SCALED;
      addr1 = '0;
      idx_u = IDX_W'(s1_index_ff[FRAC_BITS-1:0]);
      mult  = len_eff;
      priority if (len_eff == '0) begin
         kind1 = KIND_ZERO;
      end else if (len_eff == LEN_W'(1)) begin
         kind1 = KIND_ENTRY;
      end else if (clamp_mode) begin
         mult = len_last;
         priority if (s1_index_ff > ONE_FX) begin
            kind1 = KIND_ENTRY;
            addr1 = len_last[ADDR_W-1:0];
         end else if (s1_index_ff[DATA_W-1]) begin
            kind1 = KIND_ENTRY;
         end else begin
            idx_u = s1_index_ff[IDX_W-1:0];
         end
      end else begin
         kind1 = KIND_SCALED;
      end
      scaled1 = SC_W'(idx_u) * SC_W'(mult);
   end

   // integer part of the scaled index is below the length whenever the length is nonzero
   assign left      = s2_scaled_ff[FRAC_BITS +: ADDR_W];
   assign right_inc = LEN_W'(left) + LEN_W'(1);
   assign right     = (right_inc == len_eff) ? '0 : right_inc[ADDR_W-1:0];

   always_comb begin
      kind2 = s2_kind_ff;
      addr2 = s2_addr_ff;
      unique case (s2_kind_ff)
         KIND_SCALED: begin
            addr2 = left;
            kind2 = snap_mode ? KIND_ENTRY : KIND_BLEND;
         end
         KIND_ZERO,
         KIND_ENTRY: begin
            kind2 = s2_kind_ff;
         end
         default: begin
            kind2 = s2_kind_ff;
         end
      endcase
   end

   assign slot_wide = WIDE_W'(s2_slot_ff);
   assign slot_ok   = slot_wide < WIDE_W'(TABLE_DEPTH);

   assign ram_wr_en     = ready_3 && s2_valid_ff && s2_write_ff && slot_ok;
   assign ram_wr_addr   = slot_wide[ADDR_W-1:0];
   assign ram_wr_data   = s2_value_ff;
   assign ram_rd_en     = ready_3 && s2_valid_ff && !s2_write_ff;
   assign ram_rd_addr_a = addr2;
   assign ram_rd_addr_b = right;

   assign s1_valid_in = ready_1 ? req_valid : s1_valid_ff;
   assign s2_valid_in = ready_2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = ready_3 ? (s2_valid_ff && !s2_write_ff) : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_1 && req_valid) begin
         s1_write_ff <= req_operation;
         s1_slot_ff  <= req_entry_slot;
         s1_value_ff <= req_entry_value;
         s1_index_ff <= req_lookup_index;
      end
      if (ready_2 && s1_valid_ff) begin
         s2_write_ff  <= s1_write_ff;
         s2_slot_ff   <= s1_slot_ff;
         s2_value_ff  <= s1_value_ff;
         s2_kind_ff   <= kind1;
         s2_addr_ff   <= addr1;
         s2_scaled_ff <= scaled1;
      end
      if (ram_rd_en) begin
         s3_kind_ff <= kind2;
         s3_frac_ff <= s2_scaled_ff[FRAC_BITS-1:0];
      end
   end

   assign s3_ctrl.valid = s3_valid_ff;
   assign s3_ctrl.kind  = s3_kind_ff;
   assign s3_frac       = s3_frac_ff;

   `ITLU_ASSERT_ALWAYS(a_port_exclusive, !(ram_wr_en && ram_rd_en), "table written and read at once")
   `ITLU_ASSERT_NEXT(a_s2_hold, s2_valid_ff && !ready_3, s2_valid_ff && $stable(s2_scaled_ff), "stage 2 word lost in stall")
   `ITLU_ASSERT_IMPL(a_right_addr, ram_rd_en && (kind2 == KIND_BLEND), (ram_rd_addr_b == ADDR_W'(ram_rd_addr_a + 1'b1)) || (ram_rd_addr_b == '0), "right entry not next to left entry")

endmodule

// ===== rtl/itlu_blend.sv =====
// Back pipeline: interpolation products, sum and shift, result register.
// Depends on itlu_pkg; takes entries from the table RAM read registers.
module itlu_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  itlu_pkg::stage_ctrl_type             s3_ctrl,
   input  logic [FRAC_BITS-1:0]                 s3_frac,
   input  logic signed [itlu_pkg::DATA_W-1:0]   entry_a,
   input  logic signed [itlu_pkg::DATA_W-1:0]   entry_b,
   output logic                                 s4_ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [itlu_pkg::DATA_W-1:0]   rsp_result_value
);

   import itlu_pkg::*;

   localparam int W_W    = FRAC_BITS + 2;
   localparam int PROD_W = W_W + DATA_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam logic signed [W_W-1:0] ONE_W = W_W'(64'd1 << FRAC_BITS);

   logic signed [W_W-1:0]    weight_a, weight_b;
   logic signed [PROD_W-1:0] prod_a, prod_b;
   logic signed [SUM_W-1:0]  sum;
   logic [DATA_W-1:0]        result;

   logic                     s4_valid_ff, s4_valid_in;
   kind_type                 s4_kind_ff;
   logic signed [PROD_W-1:0] s4_prod_a_ff, s4_prod_b_ff;
   logic [DATA_W-1:0]        s4_entry_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_result_value_ff;
   logic                     ready_5;

   assign ready_5  = !rsp_valid_ff || rsp_ready;
   assign s4_ready = !s4_valid_ff || ready_5;

   assign weight_b = W_W'(s3_frac);
   assign weight_a = ONE_W - weight_b;
   assign prod_a   = PROD_W'(weight_a) * PROD_W'(entry_a);
   assign prod_b   = PROD_W'(weight_b) * PROD_W'(entry_b);

   // floor shift of the weighted sum; the value lies between the two entries
   assign sum = SUM_W'(s4_prod_a_ff) + SUM_W'(s4_prod_b_ff);

   always_comb begin
      unique case (s4_kind_ff)
         KIND_ZERO:  result = '0;
         KIND_ENTRY: result = s4_entry_ff;
         KIND_BLEND: result = sum[FRAC_BITS +: DATA_W];
         default:    result = '0;
      endcase
   end

   assign s4_valid_in  = s4_ready ? s3_ctrl.valid : s4_valid_ff;
   assign rsp_valid_in = ready_5 ? s4_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff  <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_ctrl.valid) begin
         s4_kind_ff   <= s3_ctrl.kind;
         s4_prod_a_ff <= prod_a;
         s4_prod_b_ff <= prod_b;
         s4_entry_ff  <= entry_a;
      end
      if (ready_5 && s4_valid_ff) begin
         rsp_result_value_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_value_ff;

endmodule
